// ===== rtl/apdu_cc_pkg.sv =====
// Shared types and constants for the APDU case classifier.
`timescale 1ns / 1ps
`default_nettype none

package apdu_cc_pkg;

	localparam int unsigned CountW   = 17;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

	// Byte positions and length offsets of the command APDU layout.
	localparam logic [CountW-1:0] IdxLenByte  = CountW'(4);
	localparam logic [CountW-1:0] IdxExtHi    = CountW'(5);
	localparam logic [CountW-1:0] IdxExtLo    = CountW'(6);
	localparam logic [CountW-1:0] LenHeader   = CountW'(4);
	localparam logic [CountW-1:0] LenCase2s   = CountW'(5);
	localparam logic [CountW-1:0] LenExtBad   = CountW'(6);
	localparam logic [CountW-1:0] LenCase2e   = CountW'(7);
	localparam logic [CountW-1:0] OffCase3s   = CountW'(5);
	localparam logic [CountW-1:0] OffCase4s   = CountW'(6);
	localparam logic [CountW-1:0] OffCase3e   = CountW'(7);
	localparam logic [CountW-1:0] OffCase4e   = CountW'(10);

	typedef enum logic [2:0] {
		CASE_NONE = 3'd0,
		CASE_1    = 3'd1,
		CASE_2S   = 3'd2,
		CASE_3S   = 3'd3,
		CASE_4S   = 3'd4,
		CASE_2E   = 3'd5,
		CASE_3E   = 3'd6,
		CASE_4E   = 3'd7
	} apdu_case_t;

	typedef enum logic [1:0] {
		LEN_NONE  = 2'd0,
		LEN_SHORT = 2'd1,
		LEN_EXT   = 2'd3
	} enc_len_t;

	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_ERR = 1'b1;

	typedef struct packed {
		logic        status;
		apdu_case_t  apdu_case;
		enc_len_t    lc_length;
		logic [15:0] lc_value;
		enc_len_t    le_length;
		logic [15:0] le_value;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/apdu_case_classifier_core.sv =====
// Top level of the command APDU case classifier.
`timescale 1ns / 1ps
`default_nettype none

// The block takes a command APDU one byte per word on the slave stream, with
// tlast on the final byte, and gives one result word per APDU on the master
// stream: OK or malformed (in tuser), the case (1, 2S, 3S, 4S, 2E, 3E or 4E),
// and Lc and Le with the number of bytes that encode each. Le is reported as
// encoded, so a zero Le is not turned into 256 or 65536. Bytes are taken at
// one per cycle with no gap between APDUs, unless a stalled result has also
// filled the capture stage. The running counters are updated as each byte
// arrives; the final byte's snapshot is captured in one stage, classified by
// a handful of add-and-compare checks, and held in the result register. A
// stalled result blocks input only once the capture stage behind it is also
// full. The byte counter saturates at 131071, and an APDU that long is
// reported as malformed.
module apdu_case_classifier_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic        s_tlast,  // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // [2:0] apdu_case, [4:3] lc_length,
	                                   // [20:5] lc_value, [22:21] le_length,
	                                   // [38:23] le_value, [39] zero
	output logic             m_tuser   // status
);

	localparam int unsigned CW = apdu_cc_pkg::CountW;

	// Running state for the APDU being received.
	logic [CW-1:0] byte_count_q;
	logic [7:0]    first_len_byte_q;
	logic [15:0]   extended_lc_q;
	logic [23:0]   tail_window_q;

	// Next values of the running state with the incoming byte applied.
	logic [CW-1:0] count_nx;
	logic [7:0]    b4_nx;
	logic [15:0]   ext_nx;
	logic [23:0]   tail_nx;

	// Snapshot of the finished APDU.
	logic          valid_s1;
	logic [CW-1:0] len_s1;
	logic [7:0]    b4_s1;
	logic [15:0]   ext_s1;
	logic [23:0]   tail_s1;

	apdu_cc_pkg::result_t res_c;
	apdu_cc_pkg::result_t res_q;
	logic                 out_valid_q;

	logic in_fire;
	logic adv_s1;

	// The capture stage moves on when the result register is empty or drained.
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;
	assign in_fire  = s_tvalid && s_tready;

	always_comb begin
		b4_nx   = first_len_byte_q;
		ext_nx  = extended_lc_q;
		if (byte_count_q == apdu_cc_pkg::IdxLenByte) begin
			b4_nx = s_tdata;
		end
		if (byte_count_q == apdu_cc_pkg::IdxExtHi) begin
			ext_nx[15:8] = s_tdata;
		end
		if (byte_count_q == apdu_cc_pkg::IdxExtLo) begin
			ext_nx[7:0] = s_tdata;
		end
		tail_nx  = {tail_window_q[15:0], s_tdata};
		count_nx = (byte_count_q == apdu_cc_pkg::CountMax) ? byte_count_q
		                                                   : byte_count_q + CW'(1);
	end

	// Running state; it returns to zero after the final byte of each APDU.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q     <= '0;
			first_len_byte_q <= '0;
			extended_lc_q    <= '0;
			tail_window_q    <= '0;
		end else if (in_fire) begin
			if (s_tlast) begin
				byte_count_q     <= '0;
				first_len_byte_q <= '0;
				extended_lc_q    <= '0;
				tail_window_q    <= '0;
			end else begin
				byte_count_q     <= count_nx;
				first_len_byte_q <= b4_nx;
				extended_lc_q    <= ext_nx;
				tail_window_q    <= tail_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire && s_tlast) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && s_tlast) begin
			len_s1  <= count_nx;
			b4_s1   <= b4_nx;
			ext_s1  <= ext_nx;
			tail_s1 <= tail_nx;
		end
	end

	// Classification of the captured APDU. Each length test is one 17-bit
	// add and compare against the captured length.
	always_comb begin
		logic [CW-1:0] b4_w;
		logic [CW-1:0] ext_w;
		b4_w  = CW'(b4_s1);
		ext_w = CW'(ext_s1);
		res_c = '{status: apdu_cc_pkg::STAT_ERR, apdu_case: apdu_cc_pkg::CASE_NONE,
		          lc_length: apdu_cc_pkg::LEN_NONE, lc_value: '0,
		          le_length: apdu_cc_pkg::LEN_NONE, le_value: '0};
		priority if (len_s1 < apdu_cc_pkg::LenHeader) begin
			res_c.status = apdu_cc_pkg::STAT_ERR;
		end else if (len_s1 == apdu_cc_pkg::LenHeader) begin
			res_c.status    = apdu_cc_pkg::STAT_OK;
			res_c.apdu_case = apdu_cc_pkg::CASE_1;
		end else if (len_s1 == apdu_cc_pkg::LenCase2s) begin
			res_c.status    = apdu_cc_pkg::STAT_OK;
			res_c.apdu_case = apdu_cc_pkg::CASE_2S;
			res_c.le_length = apdu_cc_pkg::LEN_SHORT;
			res_c.le_value  = {8'h00, b4_s1};
		end else if (b4_s1 != 8'h00) begin
			// Short Lc: reported even when the length does not fit.
			res_c.lc_length = apdu_cc_pkg::LEN_SHORT;
			res_c.lc_value  = {8'h00, b4_s1};
			if (len_s1 == b4_w + apdu_cc_pkg::OffCase3s) begin
				res_c.status    = apdu_cc_pkg::STAT_OK;
				res_c.apdu_case = apdu_cc_pkg::CASE_3S;
			end else if (len_s1 == b4_w + apdu_cc_pkg::OffCase4s) begin
				res_c.status    = apdu_cc_pkg::STAT_OK;
				res_c.apdu_case = apdu_cc_pkg::CASE_4S;
				res_c.le_length = apdu_cc_pkg::LEN_SHORT;
				res_c.le_value  = {8'h00, tail_s1[7:0]};
			end
		end else if (len_s1 == apdu_cc_pkg::LenExtBad) begin
			res_c.status = apdu_cc_pkg::STAT_ERR;
		end else if (len_s1 == apdu_cc_pkg::LenCase2e) begin
			res_c.status    = apdu_cc_pkg::STAT_OK;
			res_c.apdu_case = apdu_cc_pkg::CASE_2E;
			res_c.le_length = apdu_cc_pkg::LEN_EXT;
			res_c.le_value  = ext_s1;
		end else begin
			res_c.lc_length = apdu_cc_pkg::LEN_EXT;
			res_c.lc_value  = ext_s1;
			if (len_s1 == ext_w + apdu_cc_pkg::OffCase3e) begin
				res_c.status    = apdu_cc_pkg::STAT_OK;
				res_c.apdu_case = apdu_cc_pkg::CASE_3E;
			end else if ((len_s1 == ext_w + apdu_cc_pkg::OffCase4e) &&
			             (tail_s1[23:16] == 8'h00)) begin
				res_c.status    = apdu_cc_pkg::STAT_OK;
				res_c.apdu_case = apdu_cc_pkg::CASE_4E;
				res_c.le_length = apdu_cc_pkg::LEN_EXT;
				res_c.le_value  = tail_s1[15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.status;
	assign m_tdata  = {1'b0, res_q.le_value, res_q.le_length, res_q.lc_value,
	                   res_q.lc_length, res_q.apdu_case};

	// A malformed APDU never carries a case or an Le.
	a_err_no_case: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == apdu_cc_pkg::STAT_ERR) |->
		(res_q.apdu_case == apdu_cc_pkg::CASE_NONE &&
		 res_q.le_length == apdu_cc_pkg::LEN_NONE && res_q.le_value == 16'h0000))
		else $error("malformed APDU reported with a case or Le");

	// A well-formed APDU always names a case.
	a_ok_has_case: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == apdu_cc_pkg::STAT_OK) |->
		(res_q.apdu_case != apdu_cc_pkg::CASE_NONE))
		else $error("well-formed APDU without a case");

	// Input is held off only while a finished APDU waits in the capture stage.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled without a pending result");

	// The final byte returns the running state to its reset value.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tlast) |=> (byte_count_q == '0 && tail_window_q == '0))
		else $error("running state not cleared after the final byte");

	// A final byte always yields a captured result in the next cycle.
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tlast) |=> valid_s1)
		else $error("final byte did not reach the capture stage");

endmodule

`default_nettype wire
